@@ sv/mad_pkg.sv @@
package mad_pkg;
	localparam int COUNT_W = 7;
endpackage

@@ sv/mad_ram.sv @@
module mad_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ sv/mad_front.sv @@
// Front: stores samples, hands a closed set (count, overflow, bank) to the back.
module mad_front import mad_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_WIDTH = 16,
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
	localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                    in_last,
	output logic                    we,
	output logic [AW:0]             waddr,
	output logic [SAMPLE_WIDTH-1:0] wdata,
	output logic                    q_valid,
	input  logic                    q_ready,
	output logic [CW-1:0]           q_count,
	output logic                    q_ovf,
	output logic                    q_bank
);
	logic [CW-1:0] fill_q;
	logic          ovf_q, bank_q;
	logic          hold_q;
	logic          keep;
	assign in_ready = !hold_q;
	assign keep = fill_q != CW'(MAX_SAMPLES);
	assign we = in_valid && in_ready && keep;
	assign waddr = {bank_q, fill_q[AW-1:0]};
	assign wdata = in_sample;
	assign q_valid = hold_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; ovf_q <= 1'b0; bank_q <= 1'b0; hold_q <= 1'b0;
			q_count <= '0; q_ovf <= 1'b0; q_bank <= 1'b0;
		end else begin
			if (hold_q && q_ready) hold_q <= 1'b0;
			if (in_valid && in_ready) begin
				if (in_last) begin
					q_count <= keep ? fill_q + CW'(1) : fill_q;
					q_ovf <= ovf_q || !keep;
					q_bank <= bank_q;
					hold_q <= 1'b1;
					bank_q <= !bank_q;
					fill_q <= '0;
					ovf_q <= 1'b0;
				end else if (keep) begin
					fill_q <= fill_q + CW'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end
endmodule

@@ sv/mad_back.sv @@
// Back: counting selection. For candidate i, rank = #less, eq = #equal;
// element at index k is i where less <= k < less+eq. Done twice.
module mad_back import mad_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_WIDTH = 16,
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1,
	localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	output logic                    q_ready,
	input  logic [CW-1:0]           q_count,
	input  logic                    q_ovf,
	input  logic                    q_bank,
	output logic [AW:0]             raddr,
	input  logic [SAMPLE_WIDTH-1:0] rdata,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0] median,
	output logic [SAMPLE_WIDTH-1:0] mad,
	output logic [COUNT_W-1:0]      count,
	output logic                    overflow
);
	typedef enum logic [2:0] {IDLE, LOADC, SCAN, DONE, OUT} st_t;
	st_t st_q;
	logic [CW-1:0] n_q, i_q, j_q, less_q, eq_q;
	logic          pass_q, ovf_q, bank_q, rd_ok_q;
	logic [SAMPLE_WIDTH-1:0] cand_q, med_q;
	logic [SAMPLE_WIDTH:0] vj, vc, dj;
	logic [CW-1:0] k, eq_n, less_n;
	logic lt, eqv;
	logic [CW-1:0] idx;
	assign k = n_q >> 1;
	assign q_ready = st_q == IDLE;
	assign idx = (st_q == LOADC) ? i_q : j_q;
	assign raddr = {bank_q, idx[AW-1:0]};
	always_comb begin
		dj = {rdata[SAMPLE_WIDTH-1], rdata} - {med_q[SAMPLE_WIDTH-1], med_q};
		if (pass_q) vj = {1'b0, dj[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-dj) : dj[SAMPLE_WIDTH-1:0]};
		else vj = {rdata[SAMPLE_WIDTH-1], rdata};
		vc = pass_q ? {1'b0, cand_q} : {cand_q[SAMPLE_WIDTH-1], cand_q};
		lt = $signed(vj) < $signed(vc);
		eqv = vj == vc;
		less_n = less_q + CW'(lt);
		eq_n = eq_q + CW'(eqv);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE; out_valid <= 1'b0; pass_q <= 1'b0; rd_ok_q <= 1'b0;
		end else begin
			unique case (st_q)
				IDLE: if (q_valid) begin
					n_q <= q_count; ovf_q <= q_ovf; bank_q <= q_bank;
					pass_q <= 1'b0; i_q <= '0; st_q <= LOADC; rd_ok_q <= 1'b0;
				end
				LOADC: begin
					j_q <= '0; less_q <= '0; eq_q <= '0; rd_ok_q <= 1'b0;
					st_q <= SCAN;
				end
				SCAN: begin
					// read address runs one entry ahead of rdata
					if (!rd_ok_q) begin
						cand_q <= pass_q ? vj[SAMPLE_WIDTH-1:0] : rdata;
						rd_ok_q <= 1'b1;
						j_q <= j_q + CW'(1);
					end else begin
						less_q <= less_n; eq_q <= eq_n;
						if (j_q == n_q) st_q <= DONE;
						else j_q <= j_q + CW'(1);
					end
				end
				DONE: begin
					if (less_q <= k && k < less_q + eq_q) begin
						if (!pass_q) begin
							med_q <= cand_q; pass_q <= 1'b1; i_q <= '0;
							st_q <= LOADC;
						end else begin
							median <= med_q; mad <= cand_q;
							count <= COUNT_W'(n_q); overflow <= ovf_q;
							out_valid <= 1'b1; st_q <= OUT;
						end
					end else begin
						i_q <= i_q + CW'(1); st_q <= LOADC;
					end
				end
				OUT: if (out_ready) begin
					out_valid <= 1'b0; st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule

@@ sv/median_absolute_deviation.sv @@
// Median and MAD of a set of signed samples, last sample marked. Samples are
// taken one per cycle, while in_ready is high, into a two-bank RAM; a closed
// set is queued to a selection engine that scans the store once per candidate,
// with up to n candidates in each of two passes, n the kept count.
// Loading of the next set overlaps with selection of the previous one; once
// that next set is closed, input stalls until the engine takes it.
module median_absolute_deviation import mad_pkg::*; #(
	parameter int MAX_SAMPLES = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [SAMPLE_WIDTH-1:0] sample,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SAMPLE_WIDTH-1:0] median,
	output logic [SAMPLE_WIDTH-1:0] mad,
	output logic [COUNT_W-1:0]      count,
	output logic                    overflow
);
	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	logic we, qv, qr, qo, qb;
	logic [AW:0] wa, ra;
	logic [SAMPLE_WIDTH-1:0] wd, rd;
	logic [CW-1:0] qc;
	mad_front #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .in_sample(sample), .in_last(last),
		.we, .waddr(wa), .wdata(wd), .q_valid(qv), .q_ready(qr),
		.q_count(qc), .q_ovf(qo), .q_bank(qb));
	mad_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(2 ** (AW + 1))) u_ram (
		.clk, .we, .waddr(wa), .wdata(wd), .raddr(ra), .rdata(rd));
	mad_back #(.MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
		.clk, .arst_n, .q_valid(qv), .q_ready(qr), .q_count(qc), .q_ovf(qo),
		.q_bank(qb), .raddr(ra), .rdata(rd), .out_valid, .out_ready,
		.median, .mad, .count, .overflow);
endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import mad_pkg::*;

	localparam int DEPTH = 64;
	localparam int SW = 16;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic [SW-1:0] sample;
		logic          last;
	} sample_t;

	typedef struct packed {
		logic [SW-1:0]      median;
		logic [SW-1:0]      mad;
		logic [COUNT_W-1:0] count;
		logic               overflow;
	} stats_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [SW-1:0] sample = '0;
	logic last = 0;
	logic out_valid;
	logic out_ready = 0;
	logic [SW-1:0] median;
	logic [SW-1:0] mad;
	logic [COUNT_W-1:0] count;
	logic overflow;

	sample_t pending_q[$];
	stats_t expected_q[$];
	logic signed [SW-1:0] kept[DEPTH];
	int kept_n = 0;
	bit dropped = 0;
	int errors = 0;
	longint cycles = 0;
	bit hold_off = 0;
	bit in_fire = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;

	median_absolute_deviation dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic signed [SW:0] upper_median(logic signed [SW:0] v[DEPTH], int n);
		logic signed [SW:0] key;
		int j;
		for (int i = 1; i < n; i++) begin
			key = v[i];
			j = i;
			while (j > 0 && v[j-1] > key) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = key;
		end
		return v[n/2];
	endfunction

	task automatic accept_sample(sample_t s);
		logic signed [SW:0] w[DEPTH];
		logic signed [SW:0] med;
		logic signed [SW:0] mv;
		logic signed [SW:0] d;
		stats_t r;
		if (kept_n < DEPTH) begin
			kept[kept_n] = s.sample;
			kept_n++;
		end else begin
			dropped = 1;
		end
		if (!s.last)
			return;
		for (int i = 0; i < kept_n; i++)
			w[i] = kept[i];
		med = upper_median(w, kept_n);
		for (int i = 0; i < kept_n; i++) begin
			d = kept[i] - med;
			w[i] = d < 0 ? -d : d;
		end
		mv = upper_median(w, kept_n);
		r.median = med[SW-1:0];
		r.mad = mv[SW-1:0];
		r.count = COUNT_W'(kept_n);
		r.overflow = dropped;
		expected_q.insert(expected_q.size(), r);
		kept_n = 0;
		dropped = 0;
	endtask

	// sender: bursts and gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fire)) begin
			if (pending_q.size() == 0 || hold_off) begin
				in_valid <= 0;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 0;
			end else begin
				in_valid <= 1;
				{sample, last} <= pending_q.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(40, 1);
					gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// receiver stalls on a rolling pattern, with calm stretches
	always @(negedge clk) begin
		if (arst_n) begin
			stall_phase <= (stall_phase + 1) % 200;
			if (stall_phase < 60)
				out_ready <= 1;
			else if (stall_phase < 130)
				out_ready <= (stall_phase % 5) != 0;
			else
				out_ready <= $urandom_range(2) != 0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready)
			accept_sample('{sample, last});
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected transaction median=%h mad=%h count=%0d ovf=%b",
					$time, median, mad, count, overflow);
				errors++;
			end else begin
				stats_t e;
				e = expected_q.pop_front();
				if (median !== e.median) begin
					$display("%0t: median expected %h actual %h", $time, e.median, median);
					errors++;
				end
				if (mad !== e.mad) begin
					$display("%0t: mad expected %h actual %h", $time, e.mad, mad);
					errors++;
				end
				if (count !== e.count) begin
					$display("%0t: count expected %0d actual %0d", $time, e.count, count);
					errors++;
				end
				if (overflow !== e.overflow) begin
					$display("%0t: overflow expected %b actual %b", $time, e.overflow, overflow);
					errors++;
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [SW-1:0] rand_sample(int mode);
		case (mode)
			0: return SW'($urandom());
			1: return SW'($urandom_range(20) - 10);
			2: return $urandom_range(1) ? SW'(16'h7fff - $urandom_range(3))
				: SW'(16'h8000 + $urandom_range(3));
			default: return SW'($urandom_range(1000));
		endcase
	endfunction

	task automatic queue_item(logic [SW-1:0] v, logic l);
		sample_t s;
		s.sample = v;
		s.last = l;
		pending_q.insert(pending_q.size(), s);
	endtask

	task automatic add_set(int n, int mode);
		for (int i = 0; i < n; i++)
			queue_item(rand_sample(mode), i == n - 1);
	endtask

	initial begin
		int n;
		int total;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// single extremes, equal values, extremes mixed for widest deviation
		queue_item(16'h8000, 1'b1);
		queue_item(16'h7fff, 1'b1);
		queue_item(16'h0000, 1'b1);
		queue_item(16'h8000, 1'b0);
		queue_item(16'h7fff, 1'b1);
		queue_item(16'h8000, 1'b0);
		queue_item(16'h7fff, 1'b0);
		queue_item(16'h7fff, 1'b1);
		queue_item(16'hffff, 1'b0);
		queue_item(16'h0001, 1'b0);
		queue_item(16'hffff, 1'b0);
		queue_item(16'h0001, 1'b1);
		queue_item(16'h5555, 1'b0);
		queue_item(16'haaaa, 1'b1);
		// wait for all results before continuing
		wait (pending_q.size() == 0 && !in_valid && expected_q.size() == 0);
		hold_off = 1;
		repeat (20) @(posedge clk);
		hold_off = 0;
		// store exactly full, then overflowing with the last three samples dropped
		add_set(DEPTH, 0);
		add_set(DEPTH + 3, 2);
		total = pending_q.size();
		while (total < 1650) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(DEPTH + 6, DEPTH - 2)
				: $urandom_range(12, 1);
			add_set(n, $urandom_range(3));
			total += n;
		end
		wait (pending_q.size() == 0 && !in_valid);
		wait (expected_q.size() == 0);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

@@ median_absolute_deviation.f @@
sv/mad_pkg.sv
sv/mad_ram.sv
sv/mad_front.sv
sv/mad_back.sv
sv/median_absolute_deviation.sv
bench/testbench.sv
